[src/score_distribution_convolver_assert.svh]
// assertion helpers used by the convolver rtl
`ifndef SCORE_DISTRIBUTION_CONVOLVER_ASSERT_SVH
`define SCORE_DISTRIBUTION_CONVOLVER_ASSERT_SVH

// consequence must hold in the same cycle as the condition
`define SDC_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the condition
`define SDC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

[src/sdc_pkg.sv]
// ----------------------------------------------------------------------------
// sdc_pkg
// Widths, codes and fixed-point constants of the score distribution convolver.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int MAX_BINS_DEF   = 1024;
  localparam int PROB_FRAC_DEF  = 31;

  localparam int OP_W       = 2;
  localparam int SCORE_W    = 11;
  localparam int QSCORE_W   = 21;
  localparam int PROB_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 56;
  // offsets between column scores
  localparam int DIFF_W     = SCORE_W + 1;
  // wide signed score arithmetic
  localparam int LW         = QSCORE_W + 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_CONV   = 2'd1;
  localparam logic [OP_W-1:0] OP_PVAL   = 2'd2;
  localparam logic [OP_W-1:0] OP_THRESH = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SPAN  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BG_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_C = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_G = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_T = 2'd3;

  localparam logic [PROB_W-1:0] BG_RESET = 32'h2000_0000;

  localparam logic signed [LW-1:0] SCORE_MIN = -23'sd1048576;
  localparam logic signed [LW-1:0] SCORE_MAX = 23'sd1048575;

  // saturation level: one, or all ones when one does not fit
  function automatic logic [PROB_W-1:0] prob_max(input int frac);
    logic [63:0] one;
    one = 64'd1 << frac;
    if (frac >= PROB_W) return {PROB_W{1'b1}};
    return one[PROB_W-1:0];
  endfunction

  // one as it appears on the output, cut to the field width
  function automatic logic [PROB_W-1:0] prob_one(input int frac);
    logic [63:0] one;
    one = 64'd1 << frac;
    return one[PROB_W-1:0];
  endfunction

endpackage

[src/sdc_ram.sv]
// ----------------------------------------------------------------------------
// sdc_ram
// Simple dual-port ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/score_distribution_convolver.sv]
// ----------------------------------------------------------------------------
// score_distribution_convolver
// Score distribution of a weight matrix with upper-tail cumulative and queries.
// ----------------------------------------------------------------------------
// One item is taken at a time. Every new bin of a convolve gathers four old
// bins through the single read port of the distribution memory, and the tail
// is written in the same descending pass. After reset the init state writes
// bin zero before the first item is taken. A result waits in an output
// register; the next item is taken while it is held.
module score_distribution_convolver
  import sdc_pkg::*;
#(
  parameter int MAX_BINS       = MAX_BINS_DEF,
  parameter int PROB_FRAC_BITS = PROB_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // opcode, score_a, score_c, score_g, score_t, query_score, query_prob, zero pad
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // tail_prob, found_score, status, zero pad
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PROB_W-1:0]    cfg_data
);

`include "score_distribution_convolver_assert.svh"

  localparam int IW   = $clog2(MAX_BINS);
  localparam int CW   = $clog2(MAX_BINS + 1);
  localparam int NCW  = ((CW > DIFF_W) ? CW : DIFF_W) + 1;
  localparam int SW   = ((CW > DIFF_W) ? CW : DIFF_W) + 2;
  localparam int PW   = 64 - PROB_FRAC_BITS;
  localparam int ACW  = PW + 2;
  localparam logic [PROB_W-1:0] PMAX_V = prob_max(PROB_FRAC_BITS);
  localparam logic [PROB_W-1:0] ONE_V  = prob_one(PROB_FRAC_BITS);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_CONV = 3'd3;
  localparam logic [2:0] ST_PQ   = 3'd4;
  localparam logic [2:0] ST_SCAN = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state;

  logic [PROB_W-1:0] bg [4];

  logic [OP_W-1:0]            op;
  logic signed [SCORE_W-1:0]  sc [4];
  logic signed [QSCORE_W-1:0] qscore;
  logic [PROB_W-1:0]          qprob;

  logic signed [QSCORE_W-1:0] low_score;
  logic [CW-1:0]              bin_count;
  logic signed [QSCORE_W-1:0] new_low;
  logic [CW-1:0]              new_count;
  logic [DIFF_W-1:0]          dj [4];

  logic          iss_on;
  logic [IW-1:0] k;
  logic [1:0]    j;

  logic          v1, in1;
  logic [1:0]    j1;
  logic [IW-1:0] k1;
  logic          v2;
  logic [1:0]    j2;
  logic [IW-1:0] k2;
  logic [PW-1:0] prod2;
  logic [ACW-1:0] acc;
  logic [PROB_W:0] tacc;

  logic [PROB_W-1:0]          res_tail;
  logic signed [QSCORE_W-1:0] res_found;
  logic [STATUS_W-1:0]        res_status;
  logic [PROB_W-1:0]          out_tail;
  logic signed [QSCORE_W-1:0] out_found;
  logic [STATUS_W-1:0]        out_status;
  logic                       out_load;

  // memories
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [PROB_W-1:0] dist_wd, tail_wd;
  logic [IW-1:0]     rd_addr;
  logic [PROB_W-1:0] dist_rd, tail_rd;

  sdc_ram #(.WIDTH(PROB_W), .DEPTH(MAX_BINS)) u_dist (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(dist_wd),
    .raddr(rd_addr), .rdata(dist_rd)
  );

  sdc_ram #(.WIDTH(PROB_W), .DEPTH(MAX_BINS)) u_tail (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(tail_wd),
    .raddr(rd_addr), .rdata(tail_rd)
  );

  // convolve checks on the held item
  logic signed [SCORE_W-1:0] smin, smax;
  logic [DIFF_W-1:0]         span;
  logic [NCW-1:0]            nc_full;
  logic signed [LW-1:0]      nlow, ntop;
  logic                      span_bad, range_bad;
  logic [DIFF_W-1:0]         dj_c [4];

  always_comb begin
    smin = sc[0];
    smax = sc[0];
    for (int i = 1; i < 4; i++) begin
      if (sc[i] < smin) smin = sc[i];
      if (sc[i] > smax) smax = sc[i];
    end
    span = DIFF_W'(DIFF_W'(smax) - DIFF_W'(smin));
    for (int i = 0; i < 4; i++) begin
      dj_c[i] = DIFF_W'(DIFF_W'(sc[i]) - DIFF_W'(smin));
    end
    nc_full   = NCW'(bin_count) + NCW'(span);
    span_bad  = nc_full > NCW'(MAX_BINS);
    nlow      = LW'(low_score) + LW'(smin);
    ntop      = nlow + LW'($signed({1'b0, nc_full})) - LW'(1);
    range_bad = (nlow < SCORE_MIN) || (ntop > SCORE_MAX);
  end

  // pvalue query position
  logic signed [LW-1:0] pd;
  logic                 pd_neg, pd_high;

  always_comb begin
    pd      = LW'(qscore) - LW'(low_score);
    pd_neg  = pd[LW-1];
    pd_high = pd >= LW'($signed({1'b0, bin_count}));
  end

  // source bin of the gather read
  logic signed [SW-1:0] src;
  logic                 src_in;

  always_comb begin
    src    = SW'($signed({1'b0, k})) - SW'($signed({1'b0, dj[j]}));
    src_in = !src[SW-1] && (src[SW-2:0] < (SW-1)'(bin_count));
  end

  // product, bin sum and tail sum
  logic [63:0]       mul_full;
  logic [PW-1:0]     prod_c;
  logic [ACW-1:0]    sum_c;
  logic [PROB_W-1:0] bin_v;
  logic [PROB_W:0]   tsum;
  logic [PROB_W-1:0] tail_v;

  always_comb begin
    mul_full = 64'(dist_rd) * 64'(bg[j1]);
    prod_c   = in1 ? PW'(mul_full >> PROB_FRAC_BITS) : '0;
    sum_c    = ((j2 == 2'd0) ? '0 : acc) + ACW'(prod2);
    bin_v    = (sum_c > ACW'(PMAX_V)) ? PMAX_V : sum_c[PROB_W-1:0];
    tsum     = tacc + (PROB_W+1)'(bin_v);
    tail_v   = (tsum > (PROB_W+1)'(PMAX_V)) ? PMAX_V : tsum[PROB_W-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    dist_wd = PMAX_V;
    tail_wd = PMAX_V;
    if (state == ST_INIT || (state == ST_EXEC && op == OP_CLEAR)) begin
      wr_en = 1'b1;
    end else if (state == ST_CONV && v2 && j2 == 2'd3) begin
      wr_en   = 1'b1;
      wr_addr = k2;
      dist_wd = bin_v;
      tail_wd = tail_v;
    end
  end

  always_comb begin
    if (state == ST_EXEC) begin
      rd_addr = pd[IW-1:0];
    end else if (state == ST_CONV) begin
      rd_addr = src[IW-1:0];
    end else begin
      rd_addr = k;
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign m_tdata   = {1'b0, out_status, out_found, out_tail};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      bg[0]     <= BG_RESET;
      bg[1]     <= BG_RESET;
      bg[2]     <= BG_RESET;
      bg[3]     <= BG_RESET;
      low_score <= '0;
      bin_count <= CW'(1);
      iss_on    <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BG_A: bg[0] <= cfg_data;
          REG_BG_C: bg[1] <= cfg_data;
          REG_BG_G: bg[2] <= cfg_data;
          REG_BG_T: bg[3] <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid   <= 1'b1;
        out_tail   <= res_tail;
        out_found  <= res_found;
        out_status <= res_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_INIT: begin
          low_score <= '0;
          bin_count <= CW'(1);
          state     <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tdata[1:0];
            sc[0]  <= s_tdata[12:2];
            sc[1]  <= s_tdata[23:13];
            sc[2]  <= s_tdata[34:24];
            sc[3]  <= s_tdata[45:35];
            qscore <= s_tdata[66:46];
            qprob  <= s_tdata[98:67];
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_found <= (op == OP_THRESH) ? low_score : '0;
          unique case (op)
            OP_CLEAR: begin
              res_tail   <= '0;
              res_status <= STAT_OK;
              low_score  <= '0;
              bin_count  <= CW'(1);
              state      <= ST_DONE;
            end
            OP_CONV: begin
              res_tail   <= '0;
              res_status <= span_bad ? STAT_SPAN : (range_bad ? STAT_RANGE : STAT_OK);
              if (span_bad || range_bad) begin
                state <= ST_DONE;
              end else begin
                new_count <= nc_full[CW-1:0];
                new_low   <= nlow[QSCORE_W-1:0];
                for (int i = 0; i < 4; i++) begin
                  dj[i] <= dj_c[i];
                end
                k      <= IW'(nc_full - NCW'(1));
                j      <= 2'd0;
                tacc   <= '0;
                iss_on <= 1'b1;
                state  <= ST_CONV;
              end
            end
            OP_PVAL: begin
              res_status <= STAT_OK;
              res_tail   <= pd_neg ? ONE_V : '0;
              if (pd_neg || pd_high) begin
                state <= ST_DONE;
              end else begin
                state <= ST_PQ;
              end
            end
            OP_THRESH: begin
              res_tail   <= '0;
              res_status <= STAT_OK;
              k          <= IW'(bin_count - CW'(1));
              iss_on     <= 1'b1;
              state      <= ST_SCAN;
            end
            default: ;
          endcase
        end
        ST_CONV: begin
          // gather pipeline: issue, product, accumulate and write back
          v1 <= iss_on;
          j1 <= j;
          k1 <= k;
          in1 <= src_in;
          if (iss_on) begin
            j <= j + 2'd1;
            if (j == 2'd3) begin
              if (k == '0) iss_on <= 1'b0;
              else k <= k - IW'(1);
            end
          end
          v2    <= v1;
          j2    <= j1;
          k2    <= k1;
          prod2 <= prod_c;
          if (v2) begin
            acc <= sum_c;
            if (j2 == 2'd3) tacc <= (PROB_W+1)'(tail_v);
          end
          if (!iss_on && !v1 && !v2) begin
            low_score <= new_low;
            bin_count <= new_count;
            state     <= ST_DONE;
          end
        end
        ST_PQ: begin
          res_tail <= tail_rd;
          state    <= ST_DONE;
        end
        ST_SCAN: begin
          k1 <= k;
          if (v1 && tail_rd >= qprob) begin
            res_found <= QSCORE_W'(LW'(low_score) + LW'($signed({1'b0, k1})));
            iss_on    <= 1'b0;
            v1        <= 1'b0;
            state     <= ST_DONE;
          end else begin
            v1 <= iss_on;
            if (iss_on) begin
              if (k == '0) iss_on <= 1'b0;
              else k <= k - IW'(1);
            end
            if (!iss_on && !v1) state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SDC_ASSERT_NOW(a_out_free, clk, rst, out_load, (!m_tvalid || m_tready), "output overwritten")
  `SDC_ASSERT_NOW(a_count_range, clk, rst, (state == ST_IDLE), (bin_count != '0 && bin_count <= CW'(MAX_BINS)), "bin count out of range")
  `SDC_ASSERT_NOW(a_conv_write, clk, rst, (wr_en && state == ST_CONV), (CW'(wr_addr) < new_count), "write beyond new span")
  `SDC_ASSERT_NOW(a_err_result, clk, rst, (m_tvalid && out_status != STAT_OK), (out_tail == '0 && out_found == '0), "error result carries data")
  `SDC_ASSERT_NEXT(a_take_exec, clk, rst, (s_tvalid && s_tready), (state == ST_EXEC), "item not executed")

endmodule
